// ===== design/mpmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Multi-pattern match counter package
// Shared widths, payload types, controller commands, states and status.
// ---------------------------------------------------------------------------
package mpmc_pkg;

    localparam int MAX_NODES    = 4096;
    localparam int MAX_EDGES    = 8192;
    localparam int MAX_PATTERNS = 1024;

    localparam int NODE_W  = 12;
    localparam int HASH_W  = 13;
    localparam int PAT_W   = 10;
    localparam int PCNT_W  = 11;
    localparam int SYM_W   = 16;
    localparam int MULT_W  = 10;
    localparam int CNT_W   = 16;
    localparam int QPTR_W  = NODE_W + 1;

    typedef enum logic [1:0] {
        REQ_PATTERN = 2'd0,
        REQ_BUILD   = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_TOTAL = 2'd1,
        KIND_HITS  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_req                      req_type;
        logic signed [SYM_W-1:0]   symbol;
        logic                      final_symbol;
        logic [PAT_W-1:0]          pattern_number;
    } t_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [CNT_W-1:0]   result_value;
    } t_result;

    // One slot of the edge hash table.
    typedef struct packed {
        logic               valid;
        logic [NODE_W-1:0]  parent;
        logic [SYM_W-1:0]   sym;
        logic [NODE_W-1:0]  child;
    } t_edge;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR_HASH,
        CMD_CAPTURE,
        CMD_DECODE,
        CMD_LK_START,
        CMD_LK_RD,
        CMD_LK_CHK,
        CMD_FC_RD,
        CMD_CREATE,
        CMD_P_FIN,
        CMD_P_COMMIT,
        CMD_B_START,
        CMD_B_CHILD,
        CMD_B_SYM,
        CMD_LK_FL_RD,
        CMD_K_NEXT,
        CMD_B_SETLINK,
        CMD_B_NEXT,
        CMD_B_POP,
        CMD_B_POPD,
        CMD_B_POPD2,
        CMD_ACK,
        CMD_T_SETP,
        CMD_T_WALK,
        CMD_T_WCHK,
        CMD_T_END,
        CMD_T_CLR,
        CMD_R_START,
        CMD_R_PEND,
        CMD_R_HIT,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [5:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_LK_START,
        S_LK_RD,
        S_LK_CHK,
        S_P_LKD,
        S_P_FC,
        S_P_CREATE,
        S_P_FIN,
        S_P_COMMIT,
        S_B_START,
        S_B_CHILD,
        S_B_SYM,
        S_B_LKD,
        S_B_KN,
        S_B_SET,
        S_B_NEXT,
        S_B_POP,
        S_B_POPD,
        S_B_POPD2,
        S_B_DONE,
        S_T_LKD,
        S_T_KN,
        S_T_SETP,
        S_T_WALK,
        S_T_WCHK,
        S_T_END,
        S_T_CLR,
        S_R_START,
        S_R_PEND,
        S_R_HIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_req   req_type;
        logic   fin;
        logic   negative;
        logic   lk_empty;
        logic   lk_match;
        logic   child_nz;
        logic   key_zero;
        logic   can_create;
        logic   p_bad;
        logic   u_zero;
        logic   v_zero;
        logic   q_empty;
        logic   f_zero;
        logic   seen_eq;
        logic   tc_wrap;
        logic   rd_bad;
        logic   out_free;
        logic   clr_hash_last;
        logic   clr_node_last;
    } t_status;

    // Home slot of a (parent, symbol) key; stored symbols are never negative.
    function automatic logic [HASH_W-1:0] edge_hash(input logic [NODE_W-1:0] node,
                                                    input logic [SYM_W-1:0] sym);
        return sym[12:0] ^ {node, 1'b0} ^ {11'b0, sym[14:13]} ^ {12'b0, node[11]};
    endfunction

endpackage
`default_nettype wire

// ===== design/mpmc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/mpmc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Multi-pattern match counter datapath
// Trie memories, edge hash table, BFS queue, counters and the result register.
// ---------------------------------------------------------------------------
module mpmc_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mpmc_pkg::t_item    i_item,
    input  wire mpmc_pkg::t_cmd     i_cmd,
    output mpmc_pkg::t_status       o_status,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output mpmc_pkg::t_result       o_result
);
    import mpmc_pkg::*;

    // Control registers.
    logic [NODE_W-1:0]  r_cursor;
    logic [NODE_W-1:0]  r_match;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_tc;
    logic [NODE_W-1:0]  r_nodes;
    logic [PCNT_W-1:0]  r_npat;
    logic [NODE_W-1:0]  r_root_child;
    logic [HASH_W-1:0]  r_clr;
    logic [QPTR_W-1:0]  r_head;
    logic [QPTR_W-1:0]  r_tail;
    logic               r_ovalid;

    // Payload registers.
    t_item              r_req;
    logic [NODE_W-1:0]  r_key_node;
    logic [SYM_W-1:0]   r_key_sym;
    logic [HASH_W-1:0]  r_hidx;
    logic [NODE_W-1:0]  r_child;
    logic [NODE_W-1:0]  r_link;
    logic [NODE_W-1:0]  r_u;
    logic [NODE_W-1:0]  r_v;
    logic [NODE_W-1:0]  r_ku;
    logic [NODE_W-1:0]  r_f;
    t_result            r_res;
    t_result            r_oresult;

    // Memory ports.
    logic               hash_we;
    logic [HASH_W-1:0]  hash_waddr;
    t_edge              hash_wdata;
    t_edge              hash_rd;

    logic               fl_we;
    logic [NODE_W-1:0]  fl_waddr, fl_wdata, fl_raddr, fl_rd;
    logic               mult_we;
    logic [NODE_W-1:0]  mult_waddr, mult_raddr;
    logic [MULT_W-1:0]  mult_wdata, mult_rd;
    logic               hits_we;
    logic [NODE_W-1:0]  hits_waddr, hits_raddr;
    logic [CNT_W-1:0]   hits_wdata, hits_rd;
    logic               seen_we;
    logic [NODE_W-1:0]  seen_waddr, seen_raddr;
    logic [CNT_W-1:0]   seen_wdata, seen_rd;
    logic               nsym_we;
    logic [SYM_W-1:0]   nsym_rd;
    logic               nsib_we;
    logic [NODE_W-1:0]  nsib_wdata, nsib_rd;
    logic               fc_we;
    logic [NODE_W-1:0]  fc_waddr, fc_wdata, fc_raddr, fc_rd;
    logic               q_we;
    logic [NODE_W-1:0]  q_rd;
    logic               pend_we;
    logic [NODE_W-1:0]  pend_rd;

    logic [NODE_W-1:0]  new_node;
    logic               out_free;
    logic               seen_eq;
    logic               p_bad;
    logic [CNT_W:0]     total_sum;
    logic [CNT_W-1:0]   total_sat;
    logic [CNT_W-1:0]   hits_inc;
    logic [MULT_W-1:0]  mult_inc;

    assign new_node  = r_nodes + 1'b1;
    assign out_free  = !r_ovalid || !i_stall;
    assign seen_eq   = (seen_rd == r_tc);
    assign p_bad     = (r_child == '0)
                     || (r_req.final_symbol && (r_npat >= PCNT_W'(MAX_PATTERNS)));
    assign total_sum = {1'b0, r_total} + (CNT_W+1)'(mult_rd);
    assign total_sat = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
    assign hits_inc  = (hits_rd == '1) ? hits_rd : hits_rd + 1'b1;
    assign mult_inc  = (mult_rd == '1) ? mult_rd : mult_rd + 1'b1;

    always_comb begin
        o_status               = '0;
        o_status.req_type      = r_req.req_type;
        o_status.fin           = r_req.final_symbol;
        o_status.negative      = r_req.symbol[SYM_W-1];
        o_status.lk_empty      = !hash_rd.valid;
        o_status.lk_match      = hash_rd.valid && (hash_rd.parent == r_key_node)
                                 && (hash_rd.sym == r_key_sym);
        o_status.child_nz      = (r_child != '0);
        o_status.key_zero      = (r_key_node == '0);
        o_status.can_create    = (r_nodes < NODE_W'(MAX_NODES - 1));
        o_status.p_bad         = p_bad;
        o_status.u_zero        = (r_u == '0);
        o_status.v_zero        = (r_v == '0);
        o_status.q_empty       = (r_head == r_tail);
        o_status.f_zero        = (r_f == '0);
        o_status.seen_eq       = seen_eq;
        o_status.tc_wrap       = (r_tc == '1);
        o_status.rd_bad        = ({1'b0, r_req.pattern_number} >= r_npat);
        o_status.out_free      = out_free;
        o_status.clr_hash_last = (r_clr == '1);
        o_status.clr_node_last = (r_clr[NODE_W-1:0] == '1);
    end

    // Memory write enables and addresses.
    always_comb begin
        hash_we    = 1'b0;
        hash_waddr = r_clr;
        hash_wdata = '0;
        fl_we      = 1'b0;
        fl_waddr   = new_node;
        fl_wdata   = '0;
        fl_raddr   = r_key_node;
        mult_we    = 1'b0;
        mult_waddr = new_node;
        mult_wdata = '0;
        mult_raddr = r_f;
        hits_we    = 1'b0;
        hits_waddr = new_node;
        hits_wdata = '0;
        hits_raddr = r_f;
        seen_we    = 1'b0;
        seen_waddr = new_node;
        seen_wdata = '0;
        seen_raddr = r_f;
        nsym_we    = 1'b0;
        nsib_we    = 1'b0;
        nsib_wdata = (r_cursor == '0) ? r_root_child : fc_rd;
        fc_we      = 1'b0;
        fc_waddr   = new_node;
        fc_wdata   = '0;
        fc_raddr   = r_cursor;
        q_we       = 1'b0;
        pend_we    = 1'b0;
        case (i_cmd)
            CMD_CLR_HASH: begin
                hash_we = 1'b1;
            end
            CMD_FC_RD: begin
                fc_we = 1'b1;
            end
            CMD_CREATE: begin
                hash_we    = 1'b1;
                hash_waddr = r_hidx;
                hash_wdata = '{valid: 1'b1, parent: r_cursor, sym: r_key_sym,
                               child: new_node};
                fl_we      = 1'b1;
                mult_we    = 1'b1;
                hits_we    = 1'b1;
                seen_we    = 1'b1;
                nsym_we    = 1'b1;
                nsib_we    = 1'b1;
                fc_we      = (r_cursor != '0);
                fc_waddr   = r_cursor;
                fc_wdata   = new_node;
            end
            CMD_P_FIN: begin
                mult_raddr = r_child;
            end
            CMD_P_COMMIT: begin
                mult_we    = 1'b1;
                mult_waddr = r_child;
                mult_wdata = mult_inc;
                pend_we    = 1'b1;
            end
            CMD_B_SETLINK: begin
                fl_we    = 1'b1;
                fl_waddr = r_v;
                fl_wdata = r_link;
                q_we     = 1'b1;
            end
            CMD_B_POPD: begin
                fc_raddr = q_rd;
                fl_raddr = q_rd;
            end
            CMD_T_WALK: begin
                fl_raddr = r_f;
            end
            CMD_T_WCHK: begin
                hits_we    = !seen_eq;
                hits_waddr = r_f;
                hits_wdata = hits_inc;
                seen_we    = !seen_eq;
                seen_waddr = r_f;
                seen_wdata = r_tc;
            end
            CMD_T_CLR: begin
                seen_we    = 1'b1;
                seen_waddr = r_clr[NODE_W-1:0];
            end
            CMD_R_PEND: begin
                hits_raddr = pend_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor     <= '0;
            r_match      <= '0;
            r_total      <= '0;
            r_tc         <= CNT_W'(1);
            r_nodes      <= '0;
            r_npat       <= '0;
            r_root_child <= '0;
            r_clr        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if ((i_cmd == CMD_EMIT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd)
                CMD_CLR_HASH: begin
                    r_clr <= r_clr + 1'b1;
                end
                CMD_DECODE: begin
                end
                CMD_CREATE: begin
                    r_nodes <= new_node;
                    if (r_cursor == '0) begin
                        r_root_child <= new_node;
                    end
                end
                CMD_P_FIN: begin
                    if (p_bad) begin
                        if (r_req.final_symbol) begin
                            r_cursor <= '0;
                        end
                    end else begin
                        r_cursor <= r_child;
                    end
                end
                CMD_P_COMMIT: begin
                    r_npat   <= r_npat + 1'b1;
                    r_cursor <= '0;
                end
                CMD_B_START: begin
                    r_head <= '0;
                    r_tail <= '0;
                end
                CMD_B_SETLINK: begin
                    r_tail <= r_tail + 1'b1;
                end
                CMD_B_POP: begin
                    if (r_head != r_tail) begin
                        r_head <= r_head + 1'b1;
                    end
                end
                CMD_T_SETP: begin
                    r_match <= r_child;
                end
                CMD_T_WCHK: begin
                    if (!seen_eq) begin
                        r_total <= total_sat;
                    end
                end
                CMD_T_END: begin
                    if (r_req.final_symbol) begin
                        r_total <= '0;
                        r_match <= '0;
                        r_clr   <= '0;
                        // Wrapping the text number clears every last-text mark.
                        r_tc    <= (r_tc == '1) ? CNT_W'(1) : r_tc + 1'b1;
                    end
                end
                CMD_T_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_CAPTURE: begin
                r_req <= i_item;
            end
            CMD_DECODE: begin
                r_child    <= '0;
                r_key_sym  <= r_req.symbol;
                r_key_node <= (r_req.req_type == REQ_TEXT) ? r_match : r_cursor;
            end
            CMD_LK_START: begin
                r_hidx <= edge_hash(r_key_node, r_key_sym);
            end
            CMD_LK_CHK: begin
                if (!hash_rd.valid) begin
                    r_child <= '0;
                end else if ((hash_rd.parent == r_key_node) && (hash_rd.sym == r_key_sym)) begin
                    r_child <= hash_rd.child;
                end else begin
                    r_hidx <= r_hidx + 1'b1;
                end
            end
            CMD_CREATE: begin
                r_child <= new_node;
            end
            CMD_P_FIN: begin
                if (p_bad) begin
                    r_res <= '{result_kind: KIND_ERROR, result_value: '0};
                end
            end
            CMD_P_COMMIT, CMD_ACK: begin
                r_res <= '{result_kind: KIND_ACK, result_value: '0};
            end
            CMD_B_START: begin
                r_v <= r_root_child;
                r_u <= '0;
            end
            CMD_B_CHILD: begin
                r_link <= '0;
            end
            CMD_B_SYM: begin
                r_key_sym  <= nsym_rd;
                r_key_node <= r_ku;
            end
            CMD_LK_FL_RD: begin
                r_link <= r_child;
            end
            CMD_K_NEXT: begin
                r_key_node <= fl_rd;
            end
            CMD_B_NEXT: begin
                r_v <= nsib_rd;
            end
            CMD_B_POPD: begin
                r_u <= q_rd;
            end
            CMD_B_POPD2: begin
                r_v  <= fc_rd;
                r_ku <= fl_rd;
            end
            CMD_T_SETP: begin
                r_f <= r_child;
            end
            CMD_T_WCHK: begin
                if (!seen_eq) begin
                    r_f <= fl_rd;
                end
            end
            CMD_T_END: begin
                r_res <= '{result_kind: KIND_TOTAL, result_value: r_total};
            end
            CMD_R_START: begin
                r_res <= '{result_kind: KIND_ERROR, result_value: '0};
            end
            CMD_R_HIT: begin
                r_res <= '{result_kind: KIND_HITS, result_value: hits_rd};
            end
            CMD_EMIT: begin
                if (out_free) begin
                    r_oresult <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_oresult;

    mpmc_ram #(.WIDTH($bits(t_edge)), .DEPTH(MAX_EDGES)) u_hash (
        .i_clk(i_clk), .i_we(hash_we), .i_waddr(hash_waddr), .i_wdata(hash_wdata),
        .i_raddr(r_hidx), .o_rdata(hash_rd)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_flink (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rd)
    );

    mpmc_ram #(.WIDTH(MULT_W), .DEPTH(MAX_NODES)) u_mult (
        .i_clk(i_clk), .i_we(mult_we), .i_waddr(mult_waddr), .i_wdata(mult_wdata),
        .i_raddr(mult_raddr), .o_rdata(mult_rd)
    );

    mpmc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_hits (
        .i_clk(i_clk), .i_we(hits_we), .i_waddr(hits_waddr), .i_wdata(hits_wdata),
        .i_raddr(hits_raddr), .o_rdata(hits_rd)
    );

    mpmc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_waddr), .i_wdata(seen_wdata),
        .i_raddr(seen_raddr), .o_rdata(seen_rd)
    );

    mpmc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_NODES)) u_nsym (
        .i_clk(i_clk), .i_we(nsym_we), .i_waddr(new_node), .i_wdata(r_key_sym),
        .i_raddr(r_v), .o_rdata(nsym_rd)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nsib (
        .i_clk(i_clk), .i_we(nsib_we), .i_waddr(new_node), .i_wdata(nsib_wdata),
        .i_raddr(r_v), .o_rdata(nsib_rd)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fchild (
        .i_clk(i_clk), .i_we(fc_we), .i_waddr(fc_waddr), .i_wdata(fc_wdata),
        .i_raddr(fc_raddr), .o_rdata(fc_rd)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(r_tail[NODE_W-1:0]), .i_wdata(r_v),
        .i_raddr(r_head[NODE_W-1:0]), .o_rdata(q_rd)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PATTERNS)) u_pend (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(r_npat[PAT_W-1:0]), .i_wdata(r_child),
        .i_raddr(r_req.pattern_number), .o_rdata(pend_rd)
    );

endmodule
`default_nettype wire

// ===== design/mpmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Multi-pattern match counter controller
// Sequences loading, link building, text matching and reads over the datapath.
// ---------------------------------------------------------------------------
module mpmc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    output mpmc_pkg::t_cmd          o_cmd,
    input  wire mpmc_pkg::t_status  i_status
);
    import mpmc_pkg::*;

    t_state r_state, n_state;
    // State to resume at when a hash lookup finishes.
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_INIT:     if (i_status.clr_hash_last) n_state = S_IDLE;
            S_IDLE:     if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_status.req_type)
                    REQ_PATTERN: begin
                        if (i_status.negative) begin
                            n_state = S_P_FIN;
                        end else begin
                            n_state = S_LK_START;
                            n_ret   = S_P_LKD;
                        end
                    end
                    REQ_BUILD:   n_state = S_B_START;
                    REQ_TEXT: begin
                        if (i_status.negative) begin
                            n_state = S_T_SETP;
                        end else begin
                            n_state = S_LK_START;
                            n_ret   = S_T_LKD;
                        end
                    end
                    REQ_READ:    n_state = S_R_START;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_LK_START: n_state = S_LK_RD;
            S_LK_RD:    n_state = S_LK_CHK;
            S_LK_CHK: begin
                if (i_status.lk_empty || i_status.lk_match) n_state = r_ret;
                else n_state = S_LK_RD;
            end
            S_P_LKD: begin
                if (!i_status.child_nz && i_status.can_create) n_state = S_P_FC;
                else n_state = S_P_FIN;
            end
            S_P_FC:     n_state = S_P_CREATE;
            S_P_CREATE: n_state = S_P_FIN;
            S_P_FIN: begin
                if (i_status.p_bad) n_state = S_EMIT;
                else if (!i_status.fin) n_state = S_IDLE;
                else n_state = S_P_COMMIT;
            end
            S_P_COMMIT: n_state = S_EMIT;
            S_B_START:  n_state = S_B_CHILD;
            S_B_CHILD: begin
                if (i_status.v_zero) n_state = S_B_POP;
                else if (i_status.u_zero) n_state = S_B_SET;
                else n_state = S_B_SYM;
            end
            S_B_SYM: begin
                n_state = S_LK_START;
                n_ret   = S_B_LKD;
            end
            S_B_LKD: begin
                if (i_status.child_nz || i_status.key_zero) n_state = S_B_SET;
                else n_state = S_B_KN;
            end
            S_B_KN: begin
                n_state = S_LK_START;
                n_ret   = S_B_LKD;
            end
            S_B_SET:    n_state = S_B_NEXT;
            S_B_NEXT:   n_state = S_B_CHILD;
            S_B_POP: begin
                if (i_status.q_empty) n_state = S_B_DONE;
                else n_state = S_B_POPD;
            end
            S_B_POPD:   n_state = S_B_POPD2;
            S_B_POPD2:  n_state = S_B_CHILD;
            S_B_DONE:   n_state = S_EMIT;
            S_T_LKD: begin
                if (i_status.child_nz || i_status.key_zero) n_state = S_T_SETP;
                else n_state = S_T_KN;
            end
            S_T_KN: begin
                n_state = S_LK_START;
                n_ret   = S_T_LKD;
            end
            S_T_SETP:   n_state = S_T_WALK;
            S_T_WALK: begin
                if (i_status.f_zero) n_state = S_T_END;
                else n_state = S_T_WCHK;
            end
            S_T_WCHK: begin
                if (i_status.seen_eq) n_state = S_T_END;
                else n_state = S_T_WALK;
            end
            S_T_END: begin
                if (!i_status.fin) n_state = S_IDLE;
                else if (i_status.tc_wrap) n_state = S_T_CLR;
                else n_state = S_EMIT;
            end
            S_T_CLR:    if (i_status.clr_node_last) n_state = S_EMIT;
            S_R_START: begin
                if (i_status.rd_bad) n_state = S_EMIT;
                else n_state = S_R_PEND;
            end
            S_R_PEND:   n_state = S_R_HIT;
            S_R_HIT:    n_state = S_EMIT;
            S_EMIT:     if (i_status.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_INIT:     o_cmd = CMD_CLR_HASH;
            S_IDLE:     o_cmd = i_valid ? CMD_CAPTURE : CMD_NONE;
            S_DECODE:   o_cmd = CMD_DECODE;
            S_LK_START: o_cmd = CMD_LK_START;
            S_LK_RD:    o_cmd = CMD_LK_RD;
            S_LK_CHK:   o_cmd = CMD_LK_CHK;
            S_P_LKD:    o_cmd = CMD_NONE;
            S_P_FC:     o_cmd = CMD_FC_RD;
            S_P_CREATE: o_cmd = CMD_CREATE;
            S_P_FIN:    o_cmd = CMD_P_FIN;
            S_P_COMMIT: o_cmd = CMD_P_COMMIT;
            S_B_START:  o_cmd = CMD_B_START;
            S_B_CHILD:  o_cmd = CMD_B_CHILD;
            S_B_SYM:    o_cmd = CMD_B_SYM;
            S_B_LKD:    o_cmd = CMD_LK_FL_RD;
            S_B_KN:     o_cmd = CMD_K_NEXT;
            S_B_SET:    o_cmd = CMD_B_SETLINK;
            S_B_NEXT:   o_cmd = CMD_B_NEXT;
            S_B_POP:    o_cmd = CMD_B_POP;
            S_B_POPD:   o_cmd = CMD_B_POPD;
            S_B_POPD2:  o_cmd = CMD_B_POPD2;
            S_B_DONE:   o_cmd = CMD_ACK;
            S_T_LKD:    o_cmd = CMD_LK_FL_RD;
            S_T_KN:     o_cmd = CMD_K_NEXT;
            S_T_SETP:   o_cmd = CMD_T_SETP;
            S_T_WALK:   o_cmd = CMD_T_WALK;
            S_T_WCHK:   o_cmd = CMD_T_WCHK;
            S_T_END:    o_cmd = CMD_T_END;
            S_T_CLR:    o_cmd = CMD_T_CLR;
            S_R_START:  o_cmd = CMD_R_START;
            S_R_PEND:   o_cmd = CMD_R_PEND;
            S_R_HIT:    o_cmd = CMD_R_HIT;
            S_EMIT:     o_cmd = CMD_EMIT;
            default:    o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/multi_pattern_match_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Multi-pattern match counter
// Aho-Corasick style matcher with per-text totals and per-pattern hit counts.
// ---------------------------------------------------------------------------
// The block takes one item at a time. After reset it clears every slot of the
// edge hash table and holds stall high meanwhile. A trie edge lookup hashes
// the key once, then probes one slot after another: each probe reads the
// edge table, whose read data is registered, and the lookup stops at a
// matching or an empty slot. A pattern symbol is looked up, creates a node if
// the edge is missing and room is left, and commits the pattern when it ends
// one. A text symbol follows failure links until its edge is found, then
// walks the failure chain towards the root, counting each node not yet
// counted in this text. A read fetches the hit count of the pattern's end
// node, or an error for an unknown number. A build walks the trie
// breadth-first with a failure search per node. When the text number wraps,
// the last-text marks are cleared before the total is delivered. A result
// sits in an output register, so the next item may be taken while it waits.
// ---------------------------------------------------------------------------
module multi_pattern_match_counter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire mpmc_pkg::t_item    i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output mpmc_pkg::t_result       o_result
);
    import mpmc_pkg::*;

    t_cmd    cmd;
    t_status status;

    mpmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    mpmc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== tb/multi_pattern_match_counter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-pattern match counter testbench
// Loads pattern sets, builds links, streams texts and reads hit counts while
// both sides idle and stall at random. Every result is checked against an
// in-bench automaton model.
// ---------------------------------------------------------------------------
module multi_pattern_match_counter_tb;
    import mpmc_pkg::*;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_item   i_item;
    logic    o_valid;
    logic    i_stall;
    t_result o_result;

    multi_pattern_match_counter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Trie model: edges in creation order, edge e leads to node e+1.
    int unsigned    edge_par [MAX_EDGES];
    logic [15:0]    edge_sym [MAX_EDGES];
    int unsigned    fail_lnk [MAX_NODES];
    int unsigned    end_mult [MAX_NODES];
    int unsigned    hit_cnt  [MAX_NODES];
    int unsigned    seen_txt [MAX_NODES];
    int unsigned    pat_node [MAX_PATTERNS];
    int unsigned    bfs_q    [MAX_NODES];
    int unsigned    n_nodes;
    int unsigned    ins_cur;
    int unsigned    cur_node;
    int unsigned    txt_total;
    int unsigned    txt_num;
    int unsigned    n_pats;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches;
    int      drive_pct;
    int      accept_pct;
    int      hold_cycles;
    bit      in_taken;

    // Small alphabet for most runs so that texts hit the patterns often.
    int unsigned alpha;

    function automatic int unsigned child_of(int unsigned node, logic [15:0] sym);
        for (int unsigned e = 0; e < n_nodes; e++)
            if (edge_par[e] == node && edge_sym[e] == sym)
                return e + 1;
        return 0;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < MAX_NODES; i++) begin
            fail_lnk[i] = 0;
            end_mult[i] = 0;
            hit_cnt[i]  = 0;
            seen_txt[i] = 0;
        end
        n_nodes = 0;
        ins_cur = 0;
        cur_node = 0;
        txt_total = 0;
        txt_num = 1;
        n_pats = 0;
    endfunction

    function automatic void build_failure_links();
        int unsigned head, tail, u, v, k, steps, c;
        head = 0;
        tail = 0;
        bfs_q[tail++] = 0;
        while (head < tail) begin
            u = bfs_q[head++];
            for (int unsigned e = 0; e < n_nodes; e++) begin
                if (edge_par[e] != u)
                    continue;
                v = e + 1;
                if (u == 0) begin
                    fail_lnk[v] = 0;
                end else begin
                    k = fail_lnk[u];
                    steps = 0;
                    while (k != 0 && child_of(k, edge_sym[e]) == 0 && steps < MAX_NODES) begin
                        k = fail_lnk[k];
                        steps++;
                    end
                    c = child_of(k, edge_sym[e]);
                    fail_lnk[v] = (c == v) ? 0 : c;
                end
                if (tail < MAX_NODES)
                    bfs_q[tail++] = v;
            end
        end
    endfunction

    // Applies one item to the model; returns 1 with res filled if it answers.
    function automatic bit predict_match(input t_item it, output t_result res);
        logic [15:0] sym;
        bit          neg;
        int unsigned c, p, f, steps;
        sym = it.symbol;
        neg = sym[15];
        res.result_kind = KIND_ACK;
        res.result_value = '0;
        case (it.req_type)
            REQ_PATTERN: begin
                c = neg ? 0 : child_of(ins_cur, sym);
                if (!neg && c == 0 && n_nodes + 1 < MAX_NODES && n_nodes < MAX_EDGES) begin
                    edge_par[n_nodes] = ins_cur;
                    edge_sym[n_nodes] = sym;
                    n_nodes++;
                    c = n_nodes;
                    fail_lnk[c] = 0;
                    end_mult[c] = 0;
                    hit_cnt[c] = 0;
                    seen_txt[c] = 0;
                end
                if (c == 0 || (it.final_symbol && n_pats >= MAX_PATTERNS)) begin
                    if (it.final_symbol)
                        ins_cur = 0;
                    res.result_kind = KIND_ERROR;
                    return 1;
                end
                ins_cur = c;
                if (!it.final_symbol)
                    return 0;
                if (end_mult[c] < 1023)
                    end_mult[c]++;
                pat_node[n_pats] = c;
                n_pats++;
                ins_cur = 0;
                return 1;
            end
            REQ_BUILD: begin
                build_failure_links();
                return 1;
            end
            REQ_TEXT: begin
                p = cur_node;
                if (neg) begin
                    p = 0;
                end else begin
                    steps = 0;
                    while (p != 0 && child_of(p, sym) == 0 && steps < MAX_NODES) begin
                        p = fail_lnk[p];
                        steps++;
                    end
                    p = child_of(p, sym);
                end
                cur_node = p;
                f = p;
                steps = 0;
                while (f != 0 && seen_txt[f] != txt_num && steps < MAX_NODES) begin
                    if (hit_cnt[f] < 65535)
                        hit_cnt[f]++;
                    seen_txt[f] = txt_num;
                    txt_total += end_mult[f];
                    if (txt_total > 65535)
                        txt_total = 65535;
                    f = fail_lnk[f];
                    steps++;
                end
                if (!it.final_symbol)
                    return 0;
                res.result_kind = KIND_TOTAL;
                res.result_value = txt_total[15:0];
                txt_total = 0;
                cur_node = 0;
                txt_num = (txt_num + 1) & 16'hFFFF;
                if (txt_num == 0) begin
                    txt_num = 1;
                    for (int i = 0; i < MAX_NODES; i++)
                        seen_txt[i] = 0;
                end
                return 1;
            end
            default: begin
                if (it.pattern_number >= n_pats) begin
                    res.result_kind = KIND_ERROR;
                    return 1;
                end
                res.result_kind = KIND_HITS;
                res.result_value = hit_cnt[pat_node[it.pattern_number]][15:0];
                return 1;
            end
        endcase
    endfunction

    function automatic t_item make_item(t_req req, logic [15:0] sym, bit fin,
                                        logic [9:0] pnum);
        t_item it;
        it.req_type = req;
        it.symbol = sym;
        it.final_symbol = fin;
        it.pattern_number = pnum;
        return it;
    endfunction

    function automatic logic [15:0] rand_sym();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 16'($urandom_range(0, alpha - 1));
        else if (r < 92)
            return 16'hFFFF;
        else
            return 16'($urandom_range(0, 32767));
    endfunction

    task automatic push_item(t_item it);
        t_result res;
        if (predict_match(it, res))
            expected_results = {expected_results, res};
        pending_items = {pending_items, it};
    endtask

    task automatic push_seq(t_req req, int len);
        for (int i = 0; i < len; i++)
            push_item(make_item(req, rand_sym(), i == len - 1, 10'($urandom)));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Input handshake seen at the last rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: items change on the falling edge; a held item stays put.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) < drive_pct) begin
                i_valid <= 1'b1;
                i_item  <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) >= accept_pct);
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d value=%0d",
                             o_result.result_kind, o_result.result_value);
            end else begin
                t_result want;
                want = expected_results.pop_front();
                if (o_result.result_kind !== want.result_kind ||
                    o_result.result_value !== want.result_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind=%0d value=%0d, got kind=%0d value=%0d",
                                 want.result_kind, want.result_value,
                                 o_result.result_kind, o_result.result_value);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("multi_pattern_match_counter_tb: FAIL");
        $finish;
    end

    initial begin
        int unsigned r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        in_taken = 1'b0;
        mismatches = 0;
        drive_pct = 100;
        accept_pct = 100;
        hold_cycles = 0;
        alpha = 4;
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads before any pattern, negative and extreme symbols,
        // duplicate patterns, a text before links are built, then after.
        push_item(make_item(REQ_READ, 16'd0, 1'b0, 10'd0));
        push_item(make_item(REQ_READ, 16'd0, 1'b1, 10'h3FF));
        push_item(make_item(REQ_PATTERN, 16'h7FFF, 1'b0, 10'd0));
        push_item(make_item(REQ_PATTERN, 16'h8000, 1'b1, 10'd0));
        push_item(make_item(REQ_PATTERN, 16'd1, 1'b0, 10'd0));
        push_item(make_item(REQ_PATTERN, 16'd2, 1'b1, 10'd0));
        push_item(make_item(REQ_PATTERN, 16'd2, 1'b1, 10'd0));
        push_item(make_item(REQ_PATTERN, 16'd2, 1'b1, 10'd0));
        push_item(make_item(REQ_TEXT, 16'd1, 1'b0, 10'd0));
        push_item(make_item(REQ_TEXT, 16'd2, 1'b1, 10'd0));
        push_item(make_item(REQ_BUILD, 16'hFFFF, 1'b1, 10'h3FF));
        push_item(make_item(REQ_TEXT, 16'd1, 1'b0, 10'd0));
        push_item(make_item(REQ_TEXT, 16'd2, 1'b0, 10'd0));
        push_item(make_item(REQ_TEXT, 16'hFFFF, 1'b0, 10'd0));
        push_item(make_item(REQ_TEXT, 16'h7FFF, 1'b1, 10'd0));
        push_item(make_item(REQ_READ, 16'd0, 1'b0, 10'd0));
        push_item(make_item(REQ_READ, 16'd0, 1'b0, 10'd1));
        push_item(make_item(REQ_READ, 16'd0, 1'b0, 10'd2));
        push_item(make_item(REQ_READ, 16'h5555, 1'b1, 10'd3));
        push_item(make_item(REQ_TEXT, 16'hAAAA, 1'b1, 10'h2AA));
        push_item(make_item(REQ_TEXT, 16'h5555, 1'b1, 10'h155));
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin drive_pct = 100; accept_pct = 100; end
                1: begin drive_pct = 25;  accept_pct = 100; end
                2: begin drive_pct = 100; accept_pct = 25;  end
                3: begin drive_pct = 92;  accept_pct = 92;  end
                default: begin drive_pct = 100; accept_pct = 100; end
            endcase
            alpha = (ph == 4) ? 16 : 4;
            if (ph == 2)
                hold_cycles = 400;
            for (int n = 0; n < 110; ) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    r = $urandom_range(1, 4);
                    push_seq(REQ_PATTERN, r);
                    n += r;
                end else if (r < 38) begin
                    push_item(make_item(REQ_BUILD, 16'($urandom), 1'($urandom), 10'($urandom)));
                    n++;
                end else if (r < 80) begin
                    r = $urandom_range(1, 8);
                    push_seq(REQ_TEXT, r);
                    n += r;
                end else begin
                    push_item(make_item(REQ_READ, 16'($urandom), 1'($urandom),
                        ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                    : 10'($urandom_range(0, n_pats))));
                    n++;
                end
                if (pending_items.size() > 40)
                    while (pending_items.size() > 10)
                        @(posedge i_clk);
            end
            wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("multi_pattern_match_counter_tb: PASS");
        else
            $display("multi_pattern_match_counter_tb: FAIL");
        $finish;
    end
endmodule
